// File: rtl/core/msort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sort engine package
// Shared sizes and the bank write request type.
// ----------------------------------------------------------------------------
package msort_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

endpackage

// File: rtl/core/msort_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sort engine channels
// Valid/ready interfaces for the input words and the sorted result words.
// ----------------------------------------------------------------------------
interface msort_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [msort_pkg::DATA_W-1:0] value;
    logic                               is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface msort_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [msort_pkg::DATA_W-1:0] sorted_value;
    logic                               end_of_set;
    logic                               overflowed;

    modport source (output valid, output sorted_value, output end_of_set,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set,
                    input overflowed, output ready);
endinterface

// File: rtl/core/merge_sort_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sort engine
// Stable ascending sort of up to CAPACITY signed words per set.
// ----------------------------------------------------------------------------
//  Channel  Role    Payload
//  in_ch    sink    value[31:0] signed, is_last
//  out_ch   source  sorted_value[31:0] signed, end_of_set, overflowed
//
//  Loading accepts one word per cycle. After the last word the engine runs
//  ceil(log2 n) merge passes, each paced by the single registered read port
//  that the two banks share. Results then leave one word at a time; the next
//  word is read only once out_ch has taken the current one.
//  in_ch is not ready from the last word until the final result is taken.
//  Reset clears the control state only; the RAM banks need no clearing.
// ----------------------------------------------------------------------------
module merge_sort_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    msort_in_if.sink    in_ch,
    msort_out_if.source out_ch
);

    msort_pkg::ram_req_t                req0;
    msort_pkg::ram_req_t                req1;
    logic [msort_pkg::ADDR_W-1:0]       raddr;
    logic [msort_pkg::DATA_W-1:0]       rdata0;
    logic [msort_pkg::DATA_W-1:0]       rdata1;

    msort_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .req0   (req0),
        .req1   (req1),
        .raddr  (raddr),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    msort_ram #(
        .DEPTH (msort_pkg::CAPACITY),
        .WIDTH (msort_pkg::DATA_W)
    ) u_bank0 (
        .clk   (clk),
        .we    (req0.we),
        .waddr (req0.waddr),
        .wdata (req0.wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    msort_ram #(
        .DEPTH (msort_pkg::CAPACITY),
        .WIDTH (msort_pkg::DATA_W)
    ) u_bank1 (
        .clk   (clk),
        .we    (req1.we),
        .waddr (req1.waddr),
        .wdata (req1.wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    // The input side never opens while a result is still on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input ready while a result word is pending");

    // A merge step writes exactly one bank.
    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(req0.we && req1.we))
        else $error("both banks written in one cycle");

    // After the final word of a set is taken the block returns to loading.
    a_end_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.end_of_set) |=>
        (!out_ch.valid && in_ch.ready))
        else $error("block did not return to loading after end of set");

endmodule

// File: rtl/core/msort_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sort engine RAM bank
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module msort_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/msort_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sort engine sequencer
// Loads words into bank 0, runs bottom-up merge passes between the two banks
// through a single comparator, then streams the sorted set out.
// ----------------------------------------------------------------------------
module msort_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    msort_in_if.sink                       in_ch,
    msort_out_if.source                    out_ch,
    output msort_pkg::ram_req_t            req0,
    output msort_pkg::ram_req_t            req1,
    output logic [msort_pkg::ADDR_W-1:0]   raddr,
    input  logic [msort_pkg::DATA_W-1:0]   rdata0,
    input  logic [msort_pkg::DATA_W-1:0]   rdata1
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_LOAD  = 4'd0;
    localparam logic [ST_W-1:0] S_PASS  = 4'd1;
    localparam logic [ST_W-1:0] S_GRP   = 4'd2;
    localparam logic [ST_W-1:0] S_INA   = 4'd3;
    localparam logic [ST_W-1:0] S_INB   = 4'd4;
    localparam logic [ST_W-1:0] S_MRG   = 4'd5;
    localparam logic [ST_W-1:0] S_CAPA  = 4'd6;
    localparam logic [ST_W-1:0] S_CAPB  = 4'd7;
    localparam logic [ST_W-1:0] S_ORD   = 4'd8;
    localparam logic [ST_W-1:0] S_OCAP  = 4'd9;
    localparam logic [ST_W-1:0] S_OWAIT = 4'd10;

    localparam int CNT_W  = msort_pkg::CNT_W;
    localparam int SUM_W  = msort_pkg::SUM_W;
    localparam int ADDR_W = msort_pkg::ADDR_W;
    localparam int DATA_W = msort_pkg::DATA_W;

    logic [ST_W-1:0]   state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              ovf_reg,    ovf_next;
    logic              src_reg,    src_next;
    logic [SUM_W-1:0]  width_reg,  width_next;
    logic [SUM_W-1:0]  lo_reg,     lo_next;
    logic [CNT_W-1:0]  mid_reg,    mid_next;
    logic [CNT_W-1:0]  hi_reg,     hi_next;
    logic [CNT_W-1:0]  a_reg,      a_next;
    logic [CNT_W-1:0]  b_reg,      b_next;
    logic [CNT_W-1:0]  k_reg,      k_next;
    logic [CNT_W-1:0]  idx_reg,    idx_next;
    logic [DATA_W-1:0] head_a_reg, head_a_next;
    logic [DATA_W-1:0] head_b_reg, head_b_next;
    logic              oval_reg,   oval_next;
    logic [DATA_W-1:0] odata_reg,  odata_next;
    logic              oend_reg,   oend_next;
    logic              oovf_reg,   oovf_next;

    logic [DATA_W-1:0] rdata;
    logic [SUM_W-1:0]  n_ext;
    logic [SUM_W-1:0]  lo_mid;
    logic [SUM_W-1:0]  lo_hi;
    logic              a_live;
    logic              b_live;
    logic              take_a;
    logic [CNT_W-1:0]  a_inc;
    logic [CNT_W-1:0]  b_inc;
    logic [CNT_W-1:0]  k_inc;
    msort_pkg::ram_req_t merge_req;

    assign rdata  = src_reg ? rdata1 : rdata0;
    assign n_ext  = SUM_W'(count_reg);
    assign lo_mid = lo_reg + width_reg;
    assign lo_hi  = lo_reg + (width_reg << 1);
    assign a_inc  = a_reg + CNT_W'(1);
    assign b_inc  = b_reg + CNT_W'(1);
    assign k_inc  = k_reg + CNT_W'(1);

    // The one comparator: take the left head on ties so equal keys keep order.
    assign a_live = (a_reg < mid_reg);
    assign b_live = (b_reg < hi_reg);
    assign take_a = a_live && (!b_live || ($signed(head_a_reg) <= $signed(head_b_reg)));

    assign merge_req.we    = 1'b1;
    assign merge_req.waddr = k_reg[ADDR_W-1:0];
    assign merge_req.wdata = take_a ? head_a_reg : head_b_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        src_next    = src_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        head_a_next = head_a_reg;
        head_b_next = head_b_reg;
        oval_next   = oval_reg;
        odata_next  = odata_reg;
        oend_next   = oend_reg;
        oovf_next   = oovf_reg;
        req0        = '0;
        req1        = '0;
        raddr       = '0;
        in_ch.ready = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (count_reg < CNT_W'(msort_pkg::CAPACITY))
                    begin
                        req0.we    = 1'b1;
                        req0.waddr = count_reg[ADDR_W-1:0];
                        req0.wdata = in_ch.value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_ch.is_last)
                    begin
                        width_next = SUM_W'(1);
                        src_next   = 1'b0;
                        state_next = S_PASS;
                    end
                end
            end

            S_PASS:
            begin
                if (width_reg >= n_ext)
                begin
                    idx_next   = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = S_GRP;
                end
            end

            S_GRP:
            begin
                if (lo_reg >= n_ext)
                begin
                    // Pass complete: the destination bank now holds the data.
                    src_next   = ~src_reg;
                    width_next = width_reg << 1;
                    state_next = S_PASS;
                end
                else
                begin
                    mid_next   = (lo_mid > n_ext) ? count_reg : lo_mid[CNT_W-1:0];
                    hi_next    = (lo_hi > n_ext) ? count_reg : lo_hi[CNT_W-1:0];
                    a_next     = lo_reg[CNT_W-1:0];
                    k_next     = lo_reg[CNT_W-1:0];
                    b_next     = (lo_mid > n_ext) ? count_reg : lo_mid[CNT_W-1:0];
                    raddr      = lo_reg[ADDR_W-1:0];
                    state_next = S_INA;
                end
            end

            S_INA:
            begin
                head_a_next = rdata;
                raddr       = mid_reg[ADDR_W-1:0];
                state_next  = S_INB;
            end

            S_INB:
            begin
                head_b_next = rdata;
                state_next  = S_MRG;
            end

            S_MRG:
            begin
                if (src_reg)
                begin
                    req0 = merge_req;
                end
                else
                begin
                    req1 = merge_req;
                end
                k_next = k_inc;
                if (take_a)
                begin
                    a_next     = a_inc;
                    raddr      = a_inc[ADDR_W-1:0];
                    state_next = S_CAPA;
                end
                else
                begin
                    b_next     = b_inc;
                    raddr      = b_inc[ADDR_W-1:0];
                    state_next = S_CAPB;
                end
                if (k_inc == hi_reg)
                begin
                    lo_next    = lo_hi;
                    state_next = S_GRP;
                end
            end

            S_CAPA:
            begin
                head_a_next = rdata;
                state_next  = S_MRG;
            end

            S_CAPB:
            begin
                head_b_next = rdata;
                state_next  = S_MRG;
            end

            S_ORD:
            begin
                raddr      = idx_reg[ADDR_W-1:0];
                state_next = S_OCAP;
            end

            S_OCAP:
            begin
                odata_next = rdata;
                oend_next  = ((idx_reg + CNT_W'(1)) == count_reg);
                oovf_next  = ovf_reg;
                oval_next  = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_OWAIT;
            end

            S_OWAIT:
            begin
                if (oval_reg && out_ch.ready)
                begin
                    oval_next = 1'b0;
                    if (oend_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        raddr      = idx_reg[ADDR_W-1:0];
                        state_next = S_OCAP;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            src_reg   <= src_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        head_a_reg <= head_a_next;
        head_b_reg <= head_b_next;
        odata_reg  <= odata_next;
        oend_reg   <= oend_next;
        oovf_reg   <= oovf_next;
    end

    assign out_ch.valid        = oval_reg;
    assign out_ch.sorted_value = odata_reg;
    assign out_ch.end_of_set   = oend_reg;
    assign out_ch.overflowed   = oovf_reg;

endmodule
